[src/ldm_pkg.sv]
// Shared constants for the Laplacian dither mask block.
`default_nettype none
package ldm_pkg;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int PIX_W          = 8;
  localparam int DIM_W          = 9;
  localparam int DENS_W         = 17;
  localparam int CNT_W          = 17;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 17;
  localparam int OUT_TDATA_W    = 24;
  localparam int LAP_W          = 11;
  localparam int ERR_W          = 64;

  localparam logic [DIM_W-1:0]  WIDTH_RST   = 9'd256;
  localparam logic [DIM_W-1:0]  HEIGHT_RST  = 9'd256;
  localparam logic [DENS_W-1:0] DENSITY_RST = 17'd6554;
  localparam logic [DENS_W-1:0] DENSITY_MAX = 17'd65536;

  localparam logic signed [ERR_W-1:0] THRESH_Q16 = 64'sd8355840;
  localparam logic signed [ERR_W-1:0] FULL_Q16   = 64'sd16711680;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY = 2'd2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;
endpackage
`default_nettype wire

[src/laplacian_dither_mask_top.sv]
// Laplacian dither mask: frame store, Laplacian sum, shared divider, error diffusion.
// The first request of an image sweeps the frame (five frame store reads per pixel),
// then runs the shared divider unless the Laplacian sum is zero, then clears the
// error row, then processes one pixel. A later request runs the divider again only
// if the width changed since the last request; input is held until the result is
// taken. Synchronous reset.
`default_nettype none
module laplacian_dither_mask_top #(
  parameter int MAX_WIDTH  = ldm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ldm_pkg::MAX_HEIGHT_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [ldm_pkg::PIX_W-1:0]         s_tdata,   // pixel
  input  wire                               s_tuser,   // kind
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [ldm_pkg::OUT_TDATA_W-1:0]   m_tdata,   // mask_bit, point_count, zero pad
  output logic                              m_tlast,
  input  wire                               cfg_we,
  input  wire  [ldm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ldm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ldm_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int SUMW  = NW + LAP_W;
  localparam int D255W = DENS_W + 8;
  localparam int NUMW  = D255W + NW;
  localparam int ER_D  = MAX_WIDTH + 2;
  localparam int EAW   = $clog2(ER_D);
  localparam int DCW   = $clog2(NUMW + 1);
  localparam int PRODW = NUMW + LAP_W;
  localparam int PADW  = OUT_TDATA_W - 1 - CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LAP, S_NUM, S_DIV, S_DIVD, S_CLR, S_ERD1, S_ERD2,
    S_MUL, S_VAL, S_WR0, S_WR1
  } state_t;

  state_t state;

  logic [DIM_W-1:0]  width_r, height_r;
  logic [DENS_W-1:0] density_r;
  logic [XW-1:0]     eff_w, w_seen, x;
  logic [YW-1:0]     eff_h, y;
  logic [NW-1:0]     n_eff, load_pos, pos;
  logic [DENS_W-1:0] dens_eff;

  logic [PIX_W-1:0] fmem [DEPTH];
  logic [PIX_W-1:0] fq, c_r;
  logic [AW-1:0]    f_raddr;
  logic             f_we;
  logic [2:0]       tap;
  logic [LAP_W-1:0] nsum, lap, lap_c;
  logic signed [LAP_W+1:0] diff;
  logic [NW-1:0]    tap_pos;
  logic             sum_mode, div_pos;
  logic [SUMW-1:0]  sum;

  logic [NUMW-1:0]  dnum, scale;
  logic [SUMW-1:0]  dden;
  logic [SUMW:0]    rem, rem_sh;
  logic [DCW-1:0]   dcnt;
  logic [D255W-1:0] dens255;

  logic signed [ERR_W-1:0] emem [ER_D];
  logic signed [ERR_W-1:0] eq, ea, eb, e_wdata, err_right, diag, e, v;
  logic signed [ERR_W-1:0] er_eff, dg_eff, e7, e5, e3, f7, f5, f3, f1;
  logic [EAW-1:0]   e_raddr, e_waddr, clr_cnt;
  logic             e_we;
  logic [PRODW-1:0] prod;
  logic [CNT_W-1:0] points;
  logic             setb, last_c, x_end;
  logic [XW-1:0]    x_inc;
  logic             mask_r;
  logic [CNT_W-1:0] count_r;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata  = {{PADW{1'b0}}, count_r, mask_r};

  always_comb begin
    if (width_r == '0) eff_w = XW'(1);
    else if (int'(width_r) > MAX_WIDTH) eff_w = XW'(MAX_WIDTH);
    else eff_w = XW'(width_r);
    if (height_r == '0) eff_h = YW'(1);
    else if (int'(height_r) > MAX_HEIGHT) eff_h = YW'(MAX_HEIGHT);
    else eff_h = YW'(height_r);
    dens_eff = (density_r > DENSITY_MAX) ? DENSITY_MAX : density_r;
  end

  assign n_eff   = NW'(eff_w * eff_h);
  assign dens255 = {dens_eff, 8'b0} - D255W'(dens_eff);
  assign x_inc   = x + 1'b1;
  assign x_end   = (x_inc == eff_w);
  assign last_c  = (pos == n_eff - 1'b1);

  always_comb begin
    unique case (tap)
      3'd1:    tap_pos = (x != '0) ? pos - 1'b1 : pos;
      3'd2:    tap_pos = (x_inc < eff_w) ? pos + 1'b1 : pos;
      3'd3:    tap_pos = (y != '0) ? pos - NW'(eff_w) : pos;
      3'd4:    tap_pos = (YW'(y + 1'b1) < eff_h) ? pos + NW'(eff_w) : pos;
      default: tap_pos = pos;
    endcase
  end
  assign f_raddr = tap_pos[AW-1:0];
  assign f_we    = s_tvalid && s_tready && (s_tuser == KIND_LOAD) && (load_pos < n_eff);

  always_ff @(posedge clk) begin
    if (f_we) fmem[load_pos[AW-1:0]] <= s_tdata;
    fq <= fmem[f_raddr];
  end

  assign diff  = $signed({2'b0, nsum + LAP_W'(fq)}) - $signed({3'b0, c_r, 2'b00});
  assign lap_c = diff[LAP_W+1] ? LAP_W'(-diff) : LAP_W'(diff);

  assign rem_sh = {rem[SUMW-1:0], dnum[NUMW-1]};

  assign er_eff = (x == '0) ? '0 : err_right;
  assign dg_eff = (x == '0) ? '0 : diag;
  assign v  = $signed(ERR_W'(prod)) + er_eff + ea;
  assign e7 = (e <<< 3) - e;
  assign e5 = (e <<< 2) + e;
  assign e3 = (e <<< 1) + e;
  assign f7 = e7 >>> 4;
  assign f5 = e5 >>> 4;
  assign f3 = e3 >>> 4;
  assign f1 = e >>> 4;

  always_comb begin
    e_raddr = EAW'(x);
    if (state == S_ERD1) e_raddr = EAW'(x) + 1'b1;
    e_we    = 1'b0;
    e_waddr = EAW'(x);
    e_wdata = '0;
    unique case (state)
      S_CLR: begin
        e_we    = 1'b1;
        e_waddr = clr_cnt;
      end
      S_WR0: begin
        e_we    = (x != '0);
        e_wdata = eb + f3;
      end
      S_WR1: begin
        e_we    = 1'b1;
        e_waddr = EAW'(x) + 1'b1;
        e_wdata = dg_eff + f5;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    eq <= emem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      density_r <= DENSITY_RST;
      load_pos  <= '0;
      pos       <= '0;
      x         <= '0;
      y         <= '0;
      w_seen    <= '0;
      sum       <= '0;
      scale     <= '0;
      err_right <= '0;
      diag      <= '0;
      points    <= '0;
      m_tvalid  <= 1'b0;
      tap       <= '0;
      sum_mode  <= 1'b0;
      div_pos   <= 1'b0;
      dcnt      <= '0;
      clr_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:   width_r   <= cfg_data[DIM_W-1:0];
          REG_HEIGHT:  height_r  <= cfg_data[DIM_W-1:0];
          REG_DENSITY: density_r <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (s_tuser == KIND_LOAD) begin
              if (load_pos < n_eff) load_pos <= load_pos + 1'b1;
            end else if (load_pos >= n_eff) begin
              if (pos >= n_eff) begin
                load_pos <= '0;
                pos      <= '0;
                x        <= '0;
                y        <= '0;
              end else if (pos == '0) begin
                x        <= '0;
                y        <= '0;
                sum      <= '0;
                sum_mode <= 1'b1;
                w_seen   <= eff_w;
                tap      <= '0;
                state    <= S_LAP;
              end else if (eff_w != w_seen) begin
                dnum    <= NUMW'(pos);
                dden    <= SUMW'(eff_w);
                rem     <= '0;
                dcnt    <= DCW'(NUMW);
                div_pos <= 1'b1;
                w_seen  <= eff_w;
                state   <= S_DIV;
              end else begin
                state <= S_ERD1;
              end
            end
          end
        end
        S_LAP: begin
          tap <= (tap == 3'd5) ? 3'd0 : tap + 1'b1;
          if (tap == 3'd1) begin
            c_r  <= fq;
            nsum <= '0;
          end else if (tap != 3'd0 && tap != 3'd5) begin
            nsum <= nsum + LAP_W'(fq);
          end
          if (tap == 3'd0) eb <= eq;
          if (tap == 3'd5) begin
            if (sum_mode) begin
              sum <= sum + SUMW'(lap_c);
              if (last_c) begin
                pos   <= '0;
                x     <= '0;
                y     <= '0;
                state <= S_NUM;
              end else begin
                pos <= pos + 1'b1;
                if (x_end) begin
                  x <= '0;
                  y <= y + 1'b1;
                end else begin
                  x <= x_inc;
                end
              end
            end else begin
              lap   <= lap_c;
              state <= S_MUL;
            end
          end
        end
        S_NUM: begin
          sum_mode <= 1'b0;
          dnum     <= NUMW'(dens255 * n_eff);
          dden     <= sum;
          rem      <= '0;
          dcnt     <= DCW'(NUMW);
          div_pos  <= 1'b0;
          if (sum == '0) begin
            scale   <= '0;
            clr_cnt <= '0;
            state   <= S_CLR;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, dden}) begin
            rem  <= rem_sh - {1'b0, dden};
            dnum <= {dnum[NUMW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            dnum <= {dnum[NUMW-2:0], 1'b0};
          end
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCW'(1)) state <= S_DIVD;
        end
        S_DIVD: begin
          if (div_pos) begin
            y     <= YW'(dnum);
            x     <= XW'(rem);
            state <= S_ERD1;
          end else begin
            scale   <= dnum;
            clr_cnt <= '0;
            state   <= S_CLR;
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == EAW'(ER_D - 1)) begin
            err_right <= '0;
            diag      <= '0;
            points    <= '0;
            state     <= S_ERD1;
          end
        end
        S_ERD1: state <= S_ERD2;
        S_ERD2: begin
          ea    <= eq;
          tap   <= '0;
          state <= S_LAP;
        end
        S_MUL: begin
          prod  <= scale * lap;
          state <= S_VAL;
        end
        S_VAL: begin
          setb <= (v >= THRESH_Q16);
          if (v >= THRESH_Q16) begin
            e      <= v - FULL_Q16;
            points <= points + 1'b1;
          end else begin
            e <= v;
          end
          state <= S_WR0;
        end
        S_WR0: state <= S_WR1;
        S_WR1: begin
          err_right <= f7;
          diag      <= f1;
          m_tvalid  <= 1'b1;
          mask_r    <= setb;
          count_r   <= points;
          m_tlast   <= last_c;
          if (last_c) begin
            pos      <= '0;
            x        <= '0;
            y        <= '0;
            load_pos <= '0;
          end else begin
            pos <= pos + 1'b1;
            if (x_end) begin
              x <= '0;
              y <= y + 1'b1;
            end else begin
              x <= x_inc;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
